@@ rtl/pdm_lfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pdm_lfd_pkg
// shared types and constants of the pdm lookup-table fir decimator
// ----------------------------------------------------------------------------
`default_nettype none

package pdm_lfd_pkg;

  localparam int unsigned WINDOW_BYTES_DEF  = 40;
  localparam int unsigned STAGE_SPACING_DEF = 10;

  localparam int unsigned NUM_STAGES  = 4;
  localparam int unsigned STAGE_W     = 2;
  localparam int unsigned GROUP_BYTES = 5;
  localparam int unsigned STEP_W      = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned ROW_FIELD_W = 6;
  // wide enough for any row, phase plus offset, and phase plus group length
  localparam int unsigned ROW_CMP_W   = 9;

  typedef enum logic {
    CMD_PROCESS = 1'b0,
    CMD_WRITE   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic issue;
    logic last_issue;
    logic acc_en;
    logic acc_last;
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/pdm_lut_fir_decimator.sv @@
// ----------------------------------------------------------------------------
// pdm_lut_fir_decimator
// decimating fir for packed pdm bytes, four overlapping polyphase
// accumulators fed from partial sum lookup tables
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   tuser         tlast
// s_axis    in   bytes 0..4, table row, column, value    command       -
// m_axis    out  sample                                  stage index   last of run
//
// each lane reads its table copy once per byte of a process word, so the
// single read port of the lane ram sets the rate
// samples pass the lane ram read register and then the merge register
// a table write is visible to the next process word
// a stalled output holds the lanes once their next results are ready
// reset sets each lane's start phase and clears sums, the table is undefined until written
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_lut_fir_decimator import pdm_lfd_pkg::*; #(
  parameter int unsigned WINDOW_BYTES  = WINDOW_BYTES_DEF,
  parameter int unsigned STAGE_SPACING = STAGE_SPACING_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pdm_byte0..4, table_row, table_column, table_value, zero pad
  input  wire logic [87:0] s_axis_tdata,
  // command
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // sample
  output logic      [31:0] m_axis_tdata,
  // stage_index
  output logic      [1:0]  m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int unsigned ROW_W   = $clog2(WINDOW_BYTES);
  localparam int unsigned ADDR_W  = ROW_W + BYTE_W;
  localparam int unsigned ROW_LSB = GROUP_BYTES * BYTE_W;
  localparam int unsigned COL_LSB = ROW_LSB + ROW_FIELD_W;
  localparam int unsigned VAL_LSB = COL_LSB + BYTE_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GROUP_BYTES - 1);

  logic                  busy_q, busy_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [BYTE_W-1:0]     bytes_q [GROUP_BYTES];
  logic                  rd_valid_q, rd_last_q;
  logic                  accept, proc_acc, wr_en, row_ok, stall, fin, any_emit, load_ok;
  logic                  issue, last_issue;
  cmd_e                  cmd;
  logic [ROW_CMP_W-1:0]  wr_row;
  logic [ADDR_W-1:0]     wr_addr;
  logic [SAMPLE_W-1:0]   wr_data;
  lane_ctrl_t            ctrl;
  logic [NUM_STAGES-1:0] emit;
  logic [SAMPLE_W-1:0]   sums [NUM_STAGES];

  assign cmd      = cmd_e'(s_axis_tuser[0]);
  assign wr_row   = ROW_CMP_W'(s_axis_tdata[COL_LSB-1:ROW_LSB]);
  assign row_ok   = wr_row < ROW_CMP_W'(WINDOW_BYTES);
  assign wr_addr  = {wr_row[ROW_W-1:0], s_axis_tdata[VAL_LSB-1:COL_LSB]};
  assign wr_data  = s_axis_tdata[VAL_LSB+SAMPLE_W-1:VAL_LSB];

  assign any_emit = |emit;
  assign fin      = rd_valid_q && rd_last_q;
  assign stall    = fin && any_emit && !load_ok;

  assign issue      = busy_q && !stall;
  assign last_issue = issue && (step_q == LAST_STEP);

  assign s_axis_tready = (!busy_q || (step_q == LAST_STEP)) && !stall;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign proc_acc      = accept && (cmd == CMD_PROCESS);
  assign wr_en         = accept && (cmd == CMD_WRITE) && row_ok;

  assign ctrl.issue      = issue;
  assign ctrl.last_issue = last_issue;
  assign ctrl.acc_en     = rd_valid_q && !stall;
  assign ctrl.acc_last   = rd_last_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (proc_acc) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (last_issue) begin
      busy_d = 1'b0;
    end else if (issue) begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      step_q     <= '0;
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (!stall) begin
        rd_valid_q <= issue;
        rd_last_q  <= last_issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_acc) begin
      for (int k = 0; k < GROUP_BYTES; k++) begin
        bytes_q[k] <= s_axis_tdata[k*BYTE_W +: BYTE_W];
      end
    end
  end

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_lane
    pdm_lfd_lane #(
      .WINDOW_BYTES (WINDOW_BYTES),
      .STAGE_SPACING(STAGE_SPACING),
      .STAGE_ID     (s)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .step_i   (step_q),
      .byte_i   (bytes_q[step_q]),
      .wr_en_i  (wr_en),
      .wr_addr_i(wr_addr),
      .wr_data_i(wr_data),
      .emit_o   (emit[s]),
      .sum_o    (sums[s])
    );
  end

  pdm_lfd_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fin && any_emit && load_ok),
    .emit_i   (emit),
    .sum_i    (sums),
    .load_ok_o(load_ok),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .sample_o (m_axis_tdata),
    .stage_o  (m_axis_tuser),
    .last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/pdm_lfd_ram.sv @@
// ----------------------------------------------------------------------------
// pdm_lfd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_lfd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/pdm_lfd_lane.sv @@
// ----------------------------------------------------------------------------
// pdm_lfd_lane
// one polyphase accumulator with its own copy of the partial sum table
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_lfd_lane import pdm_lfd_pkg::*; #(
  parameter int unsigned WINDOW_BYTES  = WINDOW_BYTES_DEF,
  parameter int unsigned STAGE_SPACING = STAGE_SPACING_DEF,
  parameter int unsigned STAGE_ID      = 0
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire lane_ctrl_t                               ctrl_i,
  input  wire logic [STEP_W-1:0]                        step_i,
  input  wire logic [BYTE_W-1:0]                        byte_i,
  input  wire logic                                     wr_en_i,
  input  wire logic [$clog2(WINDOW_BYTES)+BYTE_W-1:0]   wr_addr_i,
  input  wire logic [SAMPLE_W-1:0]                      wr_data_i,
  output logic                                          emit_o,
  output logic      [SAMPLE_W-1:0]                      sum_o
);

  localparam int unsigned ROW_W     = $clog2(WINDOW_BYTES);
  localparam int unsigned ADDR_W    = ROW_W + BYTE_W;
  localparam int unsigned DEPTH     = WINDOW_BYTES * (2 ** BYTE_W);
  localparam int unsigned PHASE_RST =
    (WINDOW_BYTES - (STAGE_ID * STAGE_SPACING) % WINDOW_BYTES) % WINDOW_BYTES;

  logic [ROW_W-1:0]     phase_q, phase_d;
  logic                 emit_q, emit_d;
  logic                 oob_q;
  logic [SAMPLE_W-1:0]  acc_q, acc_d;
  logic [ROW_CMP_W-1:0] row_sum, adv;
  logic                 oob, wrap;
  logic [ADDR_W-1:0]    raddr;
  logic [SAMPLE_W-1:0]  rdata, addend;

  assign row_sum = ROW_CMP_W'(phase_q) + ROW_CMP_W'(step_i);
  assign oob     = row_sum >= ROW_CMP_W'(WINDOW_BYTES);
  assign raddr   = oob ? '0 : {row_sum[ROW_W-1:0], byte_i};
  assign adv     = ROW_CMP_W'(phase_q) + ROW_CMP_W'(GROUP_BYTES);
  assign wrap    = adv >= ROW_CMP_W'(WINDOW_BYTES);

  pdm_lfd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_data_i),
    .re_i   (ctrl_i.issue),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // rows past the window contribute nothing
  assign addend = oob_q ? '0 : rdata;
  assign sum_o  = acc_q + addend;
  assign emit_o = emit_q;

  always_comb begin
    phase_d = phase_q;
    emit_d  = emit_q;
    acc_d   = acc_q;
    if (ctrl_i.last_issue) begin
      phase_d = wrap ? '0 : adv[ROW_W-1:0];
      emit_d  = wrap;
    end
    if (ctrl_i.acc_en) begin
      acc_d = (ctrl_i.acc_last && emit_q) ? '0 : sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ROW_W'(PHASE_RST);
      emit_q  <= 1'b0;
      acc_q   <= '0;
    end else begin
      phase_q <= phase_d;
      emit_q  <= emit_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      oob_q <= oob;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pdm_lfd_merge.sv @@
// ----------------------------------------------------------------------------
// pdm_lfd_merge
// collects the finished lane sums and sends them out in stage order
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_lfd_merge import pdm_lfd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire logic [NUM_STAGES-1:0] emit_i,
  input  wire logic [SAMPLE_W-1:0]   sum_i [NUM_STAGES],
  output logic                       load_ok_o,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic      [SAMPLE_W-1:0]   sample_o,
  output logic      [STAGE_W-1:0]    stage_o,
  output logic                       last_o
);

  logic [NUM_STAGES-1:0] mask_q, mask_d, rest;
  logic [SAMPLE_W-1:0]   sum_q [NUM_STAGES];
  logic [STAGE_W-1:0]    sel;
  logic                  found, take;

  // lowest pending stage goes first
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (mask_q[i] && !found) begin
        sel   = STAGE_W'(i);
        found = 1'b1;
      end
    end
  end

  assign rest      = mask_q & ~(NUM_STAGES'(1) << sel);
  assign valid_o   = |mask_q;
  assign last_o    = (rest == '0);
  assign sample_o  = sum_q[sel];
  assign stage_o   = sel;
  assign take      = valid_o && ready_i;
  assign load_ok_o = !valid_o || (take && last_o);

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = emit_i;
    end else if (take) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= sum_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pdm_lfd_checker.sv @@
// ----------------------------------------------------------------------------
// pdm_lfd_checker
// port-level checks of the decimator output stream
// ----------------------------------------------------------------------------
`default_nettype none

module pdm_lfd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic m_fire;

  assign m_fire = m_axis_tvalid && m_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

  a_stage_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && !m_axis_tlast) |=>
      (m_axis_tvalid && (m_axis_tuser > $past(m_axis_tuser))))
    else $error("samples of one run not in rising stage order");

  a_top_stage_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == 2'd3)) |-> m_axis_tlast)
    else $error("highest stage sample not marked last");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind pdm_lut_fir_decimator pdm_lfd_checker u_pdm_lfd_checker (.*);

`default_nettype wire

@@ sim/pdm_lut_fir_decimator_test.sv @@
// ----------------------------------------------------------------------------
// pdm_lut_fir_decimator_test
// drives table writes and five-byte pdm groups into the decimator and checks
// every sample against a polyphase accumulator mirror kept in the bench.
// columns are loaded across the whole window before any byte value is used,
// so no lookup ever hits a table entry that was never written. a short table
// of directed words comes first, then random words under changing stalls.
// ----------------------------------------------------------------------------
module pdm_lut_fir_decimator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pdm_lfd_pkg::*;

  localparam int unsigned WIN           = WINDOW_BYTES_DEF;
  localparam int unsigned SPACING       = STAGE_SPACING_DEF;
  localparam int unsigned RANDOM_ITEMS  = 250;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 30;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned DIRECTED_ROWS = 22;

  typedef struct packed {
    logic [31:0] sample;
    logic [1:0]  stage;
    logic        last;
  } pcm_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [39:0] pdm;
    logic [5:0]  row;
    logic [7:0]  col;
    logic [31:0] value;
    logic        typed;
    logic [31:0] exp_sample;
    logic [1:0]  exp_stage;
  } stim_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [87:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = CMD_PROCESS;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [31:0] m_axis_tdata;
  wire  [1:0]  m_axis_tuser;
  wire         m_axis_tlast;

  int unsigned send_idle_pct = 22;
  int unsigned recv_idle_pct = 81;
  bit          hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned mismatches    = 0;

  logic [31:0] lut_mirror [WIN][256];
  int unsigned stage_phase_m [NUM_STAGES];
  logic [31:0] stage_sum_m [NUM_STAGES];
  pcm_t        step_results [$];
  pcm_t        pcm_expect_q [$];
  logic [7:0]  loaded_q [$];
  bit          col_loaded [256];

  // byte columns 00, ff, 80, 01 start with the same partial sum in every row
  stim_t directed_tbl [DIRECTED_ROWS] = '{
    '{CMD_PROCESS, 40'hFFFFFFFFFF, 6'd0,  8'h00, 32'h0,        1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'hFFFFFFFFFF, 6'd0,  8'h00, 32'h0,        1'b1, 32'd10,       2'd1},
    '{CMD_PROCESS, 40'h0000000000, 6'd63, 8'hFF, 32'hFFFFFFFF, 1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'h0000000000, 6'd63, 8'hFF, 32'hFFFFFFFF, 1'b1, 32'd10,       2'd2},
    '{CMD_WRITE,   40'hFFFFFFFFFF, 6'd40, 8'h00, 32'h7FFFFFFF, 1'b0, 32'h0,        2'd0},
    '{CMD_WRITE,   40'h0000000000, 6'd63, 8'hFF, 32'h80000000, 1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'h8080808080, 6'd0,  8'h00, 32'h0,        1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'h8080808080, 6'd0,  8'h00, 32'h0,        1'b1, 32'h0,        2'd3},
    '{CMD_PROCESS, 40'h0101010101, 6'd0,  8'h00, 32'h0,        1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'hFFFFFFFFFF, 6'd0,  8'h00, 32'h0,        1'b1, 32'h80000005, 2'd0},
    '{CMD_WRITE,   40'h0000000000, 6'd0,  8'hFF, 32'hFFFFFFFF, 1'b0, 32'h0,        2'd0},
    '{CMD_WRITE,   40'hFFFFFFFFFF, 6'd39, 8'h00, 32'h7FFFFFFF, 1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'hFF0180FF00, 6'd21, 8'h5A, 32'h5A5A5A5A, 1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'h008000_01FF, 6'd0, 8'h00, 32'h0,        1'b0, 32'h0,        2'd0},
    '{CMD_WRITE,   40'hA5A5A5A5A5, 6'd39, 8'h80, 32'h12345678, 1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'h8080808080, 6'd0,  8'h00, 32'h0,        1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'h80_00FFFF01, 6'd0, 8'h00, 32'h0,        1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'hFFFFFFFFFF, 6'd0,  8'h00, 32'h0,        1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'h0000000000, 6'd0,  8'h00, 32'h0,        1'b0, 32'h0,        2'd0},
    '{CMD_WRITE,   40'h0000000000, 6'd1,  8'h01, 32'h0,        1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'h0101010101, 6'd0,  8'h00, 32'h0,        1'b0, 32'h0,        2'd0},
    '{CMD_PROCESS, 40'h00FF010080, 6'd0,  8'h00, 32'h0,        1'b0, 32'h0,        2'd0}
  };

  pdm_lut_fir_decimator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [87:0] pack_word(logic [39:0] pdm, logic [5:0] row,
                                            logic [7:0] col, logic [31:0] value);
    return {2'b00, value, col, row, pdm};
  endfunction

  function automatic logic [31:0] pick_partial_sum();
    int unsigned roll;
    roll = $urandom_range(7);
    if (roll == 0) return 32'h7FFFFFFF;
    if (roll == 1) return 32'h80000000;
    return $urandom();
  endfunction

  function automatic void fir_predict(cmd_e cmd, logic [87:0] data);
    logic [5:0]  row;
    logic [7:0]  col;
    int unsigned ph;
    int unsigned r;
    logic [31:0] sum;
    pcm_t        tail;
    row = data[45:40];
    col = data[53:46];
    step_results.delete();
    if (cmd == CMD_WRITE) begin
      if (row < WIN) lut_mirror[row][col] = data[85:54];
      return;
    end
    for (int s = 0; s < NUM_STAGES; s++) begin
      ph  = stage_phase_m[s];
      sum = stage_sum_m[s];
      for (int k = 0; k < GROUP_BYTES; k++) begin
        r = ph + k;
        if (r < WIN) sum += lut_mirror[r][data[8*k +: 8]];
      end
      ph += GROUP_BYTES;
      if (ph >= WIN) begin
        step_results.push_back('{sample: sum, stage: 2'(s), last: 1'b0});
        ph  = 0;
        sum = '0;
      end
      stage_phase_m[s] = ph;
      stage_sum_m[s]   = sum;
    end
    if (step_results.size() > 0) begin
      tail = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
    end
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  task automatic send_word(cmd_e cmd, logic [87:0] data, bit typed = 1'b0,
                           pcm_t typed_res = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fir_predict(cmd, data);
    if (typed) pcm_expect_q.push_back(typed_res);
    else foreach (step_results[i]) pcm_expect_q.push_back(step_results[i]);
    @(negedge clk_i);
  endtask

  // output side, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pcm_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pcm_expect_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: sample=%0d stage=%0d last=%0b",
                                $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast));
      end else begin
        want = pcm_expect_q.pop_front();
        if (m_axis_tdata !== want.sample || m_axis_tuser !== want.stage ||
            m_axis_tlast !== want.last) begin
          flag_mismatch($sformatf(
            "mismatch: expected sample=%0d stage=%0d last=%0b, got %0d %0d %0b",
            $signed(want.sample), want.stage, want.last,
            $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast));
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("pdm_lut_fir_decimator_test failed");
    $finish;
  end

  initial begin
    logic [7:0]  ref_cols [4];
    logic [31:0] ref_vals [4];
    logic [39:0] noise;
    logic [39:0] pdm;
    logic [7:0]  col;
    int unsigned done;
    int unsigned roll;
    stim_t       row_s;

    ref_cols = '{8'h00, 8'hFF, 8'h80, 8'h01};
    ref_vals = '{32'h00000000, 32'h00000001, 32'h7FFFFFFF, 32'h80000000};
    for (int s = 0; s < NUM_STAGES; s++) begin
      stage_phase_m[s] = (WIN - (s * SPACING) % WIN) % WIN;
      stage_sum_m[s]   = '0;
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reference columns over the whole window
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < 4; c++) begin
        noise = {8'($urandom_range(255)), $urandom()};
        send_word(CMD_WRITE, pack_word(noise, 6'(r), ref_cols[c], ref_vals[c]));
      end
    end
    for (int c = 0; c < 4; c++) begin
      col_loaded[ref_cols[c]] = 1'b1;
      loaded_q.push_back(ref_cols[c]);
    end

    foreach (directed_tbl[i]) begin
      row_s = directed_tbl[i];
      send_word(row_s.cmd, pack_word(row_s.pdm, row_s.row, row_s.col, row_s.value),
                row_s.typed,
                '{sample: row_s.exp_sample, stage: row_s.exp_stage, last: 1'b1});
    end

    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        send_idle_pct = 81;
        recv_idle_pct = 22;
        // sender pause until the pipeline has drained
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (pcm_expect_q.size() != 0);
      end
      if (p == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
      end
      done = 0;
      while (done < RANDOM_ITEMS / 3) begin
        roll = $urandom_range(99);
        if (roll < 4 && loaded_q.size() < 24) begin
          do col = 8'($urandom_range(255)); while (col_loaded[col]);
          for (int r = 0; r < WIN; r++) begin
            noise = {8'($urandom_range(255)), $urandom()};
            send_word(CMD_WRITE, pack_word(noise, 6'(r), col, pick_partial_sum()));
          end
          col_loaded[col] = 1'b1;
          loaded_q.push_back(col);
          done += WIN;
        end else if (roll < 30) begin
          noise = {8'($urandom_range(255)), $urandom()};
          send_word(CMD_WRITE, pack_word(noise, 6'($urandom_range(63)),
                                         8'($urandom_range(255)), pick_partial_sum()));
          done++;
        end else begin
          for (int k = 0; k < GROUP_BYTES; k++)
            pdm[8*k +: 8] = loaded_q[$urandom_range(loaded_q.size() - 1)];
          send_word(CMD_PROCESS, pack_word(pdm, 6'($urandom()), 8'($urandom()),
                                           $urandom()));
          done++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pcm_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pcm_expect_q.size() == 0) begin
      $display("pdm_lut_fir_decimator_test passed");
    end else begin
      $display("pdm_lut_fir_decimator_test failed");
    end
    $finish;
  end

endmodule
